// File: rtl/core/wud_pkg.sv
package wud_pkg;

  // default operand width, in bits
  localparam int unsigned OPERAND_BITS_DEF = 256;

  // width of every limb on the stream ports
  localparam int unsigned LIMB_BITS = 64;
  localparam int unsigned LIMBS     = 4;
  localparam int unsigned WIDE_BITS = LIMB_BITS * LIMBS;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic den_zero;
  } sts_t;

endpackage

// File: rtl/core/wud_datapath.sv
module wud_datapath #(
  parameter int unsigned OperandBits = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wud_pkg::ctl_t              ctl_i,
  output wud_pkg::sts_t              sts_o,
  input  logic [OperandBits-1:0]     dividend_i,
  input  logic [OperandBits-1:0]     divisor_i,
  output logic [OperandBits-1:0]     quotient_o,
  output logic [OperandBits-1:0]     remainder_o,
  output logic                       zero_divisor_o
);
  import wud_pkg::*;

  logic [OperandBits-1:0] num_q, num_d;
  logic [OperandBits-1:0] den_q, den_d;
  logic [OperandBits-1:0] rem_q, rem_d;
  logic [OperandBits-1:0] quo_q, quo_d;
  logic                   zero_q, zero_d;

  logic [OperandBits:0]   shifted;
  logic [OperandBits+1:0] diff;
  logic                   ge;

  // divisor zero check on the incoming operand
  assign sts_o.den_zero = (divisor_i == '0);

  // shared shift and subtract unit: one quotient bit per step
  always_comb begin
    shifted = {rem_q, num_q[OperandBits-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = ~diff[OperandBits+1];
  end

  // next values of the working registers
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    zero_d = zero_q;
    if (ctl_i.load) begin
      num_d  = dividend_i;
      den_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
      zero_d = sts_o.den_zero;
    end else if (ctl_i.step) begin
      num_d = {num_q[OperandBits-2:0], 1'b0};
      rem_d = ge ? diff[OperandBits-1:0] : shifted[OperandBits-1:0];
      quo_d = {quo_q[OperandBits-2:0], ge};
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // zero divisor flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
    end else begin
      zero_q <= zero_d;
    end
  end

  assign quotient_o     = quo_q;
  assign remainder_o    = rem_q;
  assign zero_divisor_o = zero_q;

endmodule

// File: rtl/core/wud_ctrl.sv
module wud_ctrl #(
  parameter int unsigned OperandBits = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  wud_pkg::sts_t sts_i,
  output wud_pkg::ctl_t ctl_o
);
  import wud_pkg::*;

  localparam int unsigned CntW = $clog2(OperandBits);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_xfer;

  assign in_xfer = in_valid_i && (state_q == ST_IDLE);

  // next state and bit counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = CntW'(OperandBits - 1);
          state_d = sts_i.den_zero ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_xfer;
      end
      ST_RUN: begin
        ctl_o.step = 1'b1;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/core/wide_unsigned_divider.sv
// Wide unsigned divider: quotient and remainder of two unsigned operands of
// OPERAND_BITS bits (64 to 256), each carried as four 64-bit limbs.
// Input stream s_axis: one transfer carries dividend and divisor; only the
// low OPERAND_BITS bits of each take part.
// Output stream m_axis: one transfer per input transfer with the quotient
// and remainder limbs in tdata and the zero-divisor flag in tuser. A zero
// divisor gives quotient 0, remainder 0 and the flag set.
// Timing: restoring division, one quotient bit per cycle from a single
// shared subtract-and-compare unit across the full operand width. After the
// input transfer the unit steps once per quotient bit; a zero divisor skips
// the steps and goes straight to the result. One item is in flight at a
// time: s_axis_tready is high only while the unit is empty.
// Reset clears the sequencer: no result is pending and s_axis_tready rises.
// When the receiver stalls, the result stays on m_axis until taken and no
// new input is accepted.
module wide_unsigned_divider #(
  parameter int unsigned OPERAND_BITS = wud_pkg::OPERAND_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata from bit 0 up: dividend_limb3, dividend_limb2, dividend_limb1,
  // dividend_limb0, divisor_limb3, divisor_limb2, divisor_limb1,
  // divisor_limb0, 64 bits each
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [511:0] s_axis_tdata,
  // tdata from bit 0 up: quotient_hi, quotient_mh, quotient_ml, quotient_lo,
  // remainder_hi, remainder_mh, remainder_ml, remainder_lo, 64 bits each
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [511:0] m_axis_tdata,
  // tuser: zero_divisor
  output logic         m_axis_tuser
);
  import wud_pkg::*;

  logic [WIDE_BITS-1:0]    dividend_wide;
  logic [WIDE_BITS-1:0]    divisor_wide;
  logic [WIDE_BITS-1:0]    quotient_wide;
  logic [WIDE_BITS-1:0]    remainder_wide;
  logic [OPERAND_BITS-1:0] quotient;
  logic [OPERAND_BITS-1:0] remainder;
  ctl_t                    ctl;
  sts_t                    sts;

  // reassemble the operands, most significant limb first on the bus
  assign dividend_wide = {s_axis_tdata[63:0],    s_axis_tdata[127:64],
                          s_axis_tdata[191:128], s_axis_tdata[255:192]};
  assign divisor_wide  = {s_axis_tdata[319:256], s_axis_tdata[383:320],
                          s_axis_tdata[447:384], s_axis_tdata[511:448]};

  wud_ctrl #(
    .OperandBits (OPERAND_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  wud_datapath #(
    .OperandBits (OPERAND_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .dividend_i     (dividend_wide[OPERAND_BITS-1:0]),
    .divisor_i      (divisor_wide[OPERAND_BITS-1:0]),
    .quotient_o     (quotient),
    .remainder_o    (remainder),
    .zero_divisor_o (m_axis_tuser)
  );

  // results zero-extended to the full bus width
  assign quotient_wide  = WIDE_BITS'(quotient);
  assign remainder_wide = WIDE_BITS'(remainder);

  assign m_axis_tdata = {remainder_wide[63:0],    remainder_wide[127:64],
                         remainder_wide[191:128], remainder_wide[255:192],
                         quotient_wide[63:0],     quotient_wide[127:64],
                         quotient_wide[191:128],  quotient_wide[255:192]};

endmodule
